[design/nrt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_pkg
// Shared codes and types for the nonce replay table.
// ----------------------------------------------------------------------------
package nrt_pkg;

  // request codes
  localparam logic [1:0] CMD_VALIDATE = 2'd0;
  localparam logic [1:0] CMD_UPDATE   = 2'd1;
  localparam logic [1:0] CMD_CREATE   = 2'd2;

  // limit register reset value
  localparam logic [10:0] LIMIT_RESET = 11'd1000;

  // result codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_REPLAY   = 2'd2,
    ST_DUP      = 2'd3
  } status_e;

  // write strobes toward the record store
  typedef struct packed {
    logic all;    // nonce, count and creation time
    logic count;  // count only
  } wr_en_t;

endpackage

[design/nrt_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nrt_store
// Record memories: nonce, use count and creation time, one read port with
// registered data and one write port.
// ----------------------------------------------------------------------------
module nrt_store
  import nrt_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int IW    = 10
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [IW-1:0] rd_addr_i,
  output logic [63:0]   rd_nonce_o,
  output logic [31:0]   rd_count_o,
  output logic [31:0]   rd_created_o,
  input  wr_en_t        wr_en_i,
  input  logic [IW-1:0] wr_addr_i,
  input  logic [63:0]   wr_nonce_i,
  input  logic [31:0]   wr_count_i,
  input  logic [31:0]   wr_created_i
);

  logic [63:0] nonce_mem   [DEPTH];
  logic [31:0] count_mem   [DEPTH];
  logic [31:0] created_mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i.all) begin
      nonce_mem[wr_addr_i]   <= wr_nonce_i;
      created_mem[wr_addr_i] <= wr_created_i;
    end
    if (wr_en_i.all || wr_en_i.count) begin
      count_mem[wr_addr_i] <= wr_count_i;
    end
  end

  // read port, registered data
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_nonce_o   <= nonce_mem[rd_addr_i];
      rd_count_o   <= count_mem[rd_addr_i];
      rd_created_o <= created_mem[rd_addr_i];
    end
  end

endmodule

[design/nonce_replay_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nonce_replay_table
// Replay cache of nonce records with validate, update and create requests.
// ----------------------------------------------------------------------------
// One request is handled at a time. Each request sweeps the records in use
// through the single read port of the record memory, one record per cycle,
// looking for the first matching nonce and, in the same pass, for the
// oldest creation time. The next request may be transferred in while the
// previous result still waits on the output.
module nonce_replay_table
  import nrt_pkg::*;
#(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [10:0] cfg_entry_limit_i,
  // requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [63:0] nonce_value_i,
  input  logic [31:0] use_count_i,
  input  logic [31:0] now_time_i,
  // results
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [9:0]  slot_index_o,
  output logic        evicted_o,
  output logic [63:0] accepted_nonce_o
);

  localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int XW = (IW > 10) ? IW : 10;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  state_e      state_q;
  logic [10:0] limit_q;
  logic [10:0] used_q;

  // request registers
  logic [1:0]  cmd_q;
  logic [63:0] key_q;
  logic [31:0] use_cnt_q;
  logic [31:0] now_q;

  // sweep registers
  logic [CW-1:0] scan_q;
  logic          chk_q;
  logic [IW-1:0] chk_idx_q;
  logic          hit_q;
  logic [IW-1:0] hit_idx_q;
  logic [31:0]   hit_count_q;
  logic [31:0]   min_time_q;
  logic [IW-1:0] min_idx_q;

  // result registers
  logic        out_valid_q;
  status_e     status_q;
  logic [9:0]  slot_q;
  logic        evicted_q;
  logic [63:0] echo_q;

  // memory signals
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [63:0]   rd_nonce;
  logic [31:0]   rd_count;
  logic [31:0]   rd_created;
  wr_en_t        wr_en;
  logic [IW-1:0] wr_addr;
  logic [31:0]   wr_count;

  // decision signals
  logic          more;
  logic          out_free;
  logic [31:0]   lim;
  status_e       dec_status;
  logic [IW-1:0] dec_slot;
  logic [XW-1:0] dec_slot_x;
  logic          dec_ev;
  logic [63:0]   dec_echo;
  logic          dec_inc;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_free    = !out_valid_q || out_ready_i;

  // sweep read address
  assign more    = (32'(scan_q) < 32'(used_q));
  assign rd_en   = (state_q == S_SCAN) && more;
  assign rd_addr = scan_q[IW-1:0];

  // effective limit: zero acts as one, clamp to the depth
  always_comb begin
    lim = (limit_q == 11'd0) ? 32'd1 : 32'(limit_q);
    if (lim > 32'(TABLE_DEPTH)) begin
      lim = 32'(TABLE_DEPTH);
    end
  end

  // outcome of a finished sweep
  always_comb begin
    dec_status = ST_NOTFOUND;
    dec_slot   = '0;
    dec_ev     = 1'b0;
    dec_echo   = '0;
    dec_inc    = 1'b0;
    wr_en      = '0;
    wr_addr    = hit_idx_q;
    wr_count   = use_cnt_q;
    case (cmd_q)
      CMD_VALIDATE, CMD_UPDATE: begin
        if (hit_q) begin
          dec_slot = hit_idx_q;
          if (use_cnt_q <= hit_count_q) begin
            dec_status = ST_REPLAY;
          end else begin
            dec_status  = ST_OK;
            wr_en.count = (cmd_q == CMD_UPDATE);
          end
        end
      end
      CMD_CREATE: begin
        if (hit_q) begin
          dec_status = ST_DUP;
          dec_slot   = hit_idx_q;
        end else begin
          dec_status = ST_OK;
          dec_echo   = key_q;
          wr_en.all  = 1'b1;
          wr_count   = '0;
          if (32'(used_q) < lim) begin
            dec_slot = IW'(used_q);
            dec_inc  = 1'b1;
          end else begin
            dec_slot = min_idx_q;
            dec_ev   = 1'b1;
          end
          wr_addr = dec_slot;
        end
      end
      default: begin
        dec_status = ST_NOTFOUND;
      end
    endcase
    if (state_q != S_DONE || !out_free) begin
      wr_en = '0;
    end
  end

  assign dec_slot_x = XW'(dec_slot);

  // control, sweep and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= LIMIT_RESET;
      used_q      <= '0;
      out_valid_q <= 1'b0;
      scan_q      <= '0;
      chk_q       <= 1'b0;
      hit_q       <= 1'b0;
      cmd_q       <= CMD_VALIDATE;
      key_q       <= '0;
      use_cnt_q   <= '0;
      now_q       <= '0;
      chk_idx_q   <= '0;
      hit_idx_q   <= '0;
      hit_count_q <= '0;
      min_time_q  <= '0;
      min_idx_q   <= '0;
      status_q    <= ST_OK;
      slot_q      <= '0;
      evicted_q   <= 1'b0;
      echo_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        limit_q <= cfg_entry_limit_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            cmd_q     <= command_i;
            key_q     <= nonce_value_i;
            use_cnt_q <= use_count_i;
            now_q     <= now_time_i;
            scan_q    <= '0;
            chk_q     <= 1'b0;
            hit_q     <= 1'b0;
            state_q   <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue the next read
          chk_q     <= more;
          chk_idx_q <= scan_q[IW-1:0];
          if (more) begin
            scan_q <= scan_q + 1'b1;
          end
          // check the record that came back
          if (chk_q) begin
            if (!hit_q && rd_nonce == key_q) begin
              hit_q       <= 1'b1;
              hit_idx_q   <= chk_idx_q;
              hit_count_q <= rd_count;
            end
            if (chk_idx_q == '0 || rd_created < min_time_q) begin
              min_time_q <= rd_created;
              min_idx_q  <= chk_idx_q;
            end
          end
          if (!more && !chk_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= dec_status;
            slot_q      <= dec_slot_x[9:0];
            evicted_q   <= dec_ev;
            echo_q      <= dec_echo;
            if (dec_inc) begin
              used_q <= used_q + 11'd1;
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // record memory
  nrt_store #(
    .DEPTH(TABLE_DEPTH),
    .IW   (IW)
  ) u_store (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_nonce_o  (rd_nonce),
    .rd_count_o  (rd_count),
    .rd_created_o(rd_created),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_nonce_i  (key_q),
    .wr_count_i  (wr_count),
    .wr_created_i(now_q)
  );

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign slot_index_o     = slot_q;
  assign evicted_o        = evicted_q;
  assign accepted_nonce_o = echo_q;

endmodule

[tb/tb_nonce_replay_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nonce_replay_table
// Self-checking bench for the nonce replay table.
// ----------------------------------------------------------------------------
// A queue of requests feeds a clocked driver. Every accepted request runs
// through a local model of the record table, and the answer it gives is
// queued. A clocked monitor compares each result transfer, field by field,
// with the oldest queued answer. The entry limit is rewritten between phases
// while the block is idle: a directed opening covers the corner cases, then
// random traffic mostly hits nonces that were created earlier. Sender gaps
// and receiver stalls rotate through several mixes as requests go by.
// ----------------------------------------------------------------------------
module tb_nonce_replay_table
  import nrt_pkg::*;
();

  localparam int          TBL_DEPTH    = 1024;
  localparam int          STALL_LIMIT  = 20000;
  localparam int          DRAIN_CYCLES = TBL_DEPTH + 50;
  localparam int          POOL_MAX     = 200;
  localparam logic [1:0]  CMD_UNUSED   = 2'd3;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] nonce;
    logic [31:0] count;
    logic [31:0] now;
  } request_t;

  typedef struct packed {
    status_e     status;
    logic [9:0]  slot;
    logic        evicted;
    logic [63:0] echo;
  } outcome_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  // block inputs, all known from time zero
  logic        cfg_valid = 1'b0;
  logic [10:0] cfg_data  = LIMIT_RESET;
  logic        req_valid = 1'b0;
  logic [1:0]  req_cmd   = CMD_VALIDATE;
  logic [63:0] req_nonce = '0;
  logic [31:0] req_count = '0;
  logic [31:0] req_now   = '0;
  logic        resp_ready = 1'b0;

  // block outputs
  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [1:0]  status_o;
  logic [9:0]  slot_index_o;
  logic        evicted_o;
  logic [63:0] accepted_nonce_o;

  nonce_replay_table DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_entry_limit_i(cfg_data),
    .in_valid_i       (req_valid),
    .in_ready_o       (in_ready_o),
    .command_i        (req_cmd),
    .nonce_value_i    (req_nonce),
    .use_count_i      (req_count),
    .now_time_i       (req_now),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (resp_ready),
    .status_o         (status_o),
    .slot_index_o     (slot_index_o),
    .evicted_o        (evicted_o),
    .accepted_nonce_o (accepted_nonce_o)
  );

  // request feed and answers still owed by the block
  request_t nonce_requests [$];
  outcome_t expected_answers [$];
  int unsigned accepted_reqs = 0;
  int mismatches = 0;

  // local copy of the record table
  logic [63:0] row_nonce [TBL_DEPTH];
  logic [31:0] row_count [TBL_DEPTH];
  logic [31:0] row_born  [TBL_DEPTH];
  int          rows_used   = 0;
  logic [10:0] limit_model = LIMIT_RESET;

  // generator side memory of created nonces and counts sent for them
  logic [63:0] known_nonces [$];
  logic [31:0] known_counts [$];
  logic [31:0] clock_secs = 32'd100;

  // answer for one request, updating the local table
  function automatic outcome_t table_answer(input request_t r);
    outcome_t a;
    int i, hit, span, lim, slot;
    a.status  = ST_NOTFOUND;
    a.slot    = '0;
    a.evicted = 1'b0;
    a.echo    = '0;
    span = (rows_used > TBL_DEPTH) ? TBL_DEPTH : rows_used;
    hit  = -1;
    for (i = 0; i < span && hit < 0; i++) begin
      if (row_nonce[i] == r.nonce) hit = i;
    end
    if (r.cmd == CMD_VALIDATE || r.cmd == CMD_UPDATE) begin
      if (hit >= 0) begin
        a.slot = 10'(hit);
        if (r.count <= row_count[hit]) begin
          a.status = ST_REPLAY;
        end else begin
          a.status = ST_OK;
          if (r.cmd == CMD_UPDATE) row_count[hit] = r.count;
        end
      end
    end else if (r.cmd == CMD_CREATE) begin
      if (hit >= 0) begin
        a.status = ST_DUP;
        a.slot   = 10'(hit);
      end else begin
        lim = int'(limit_model);
        if (lim == 0) lim = 1;
        if (lim > TBL_DEPTH) lim = TBL_DEPTH;
        if (rows_used < lim) begin
          slot      = rows_used;
          rows_used = (rows_used + 1) & 'h7FF;
        end else begin
          // oldest record, lowest slot on ties
          slot = 0;
          for (i = 1; i < span; i++) begin
            if (row_born[i] < row_born[slot]) slot = i;
          end
          a.evicted = 1'b1;
        end
        row_nonce[slot] = r.nonce;
        row_count[slot] = '0;
        row_born[slot]  = r.now;
        a.status = ST_OK;
        a.slot   = 10'(slot);
        a.echo   = r.nonce;
      end
    end
    return a;
  endfunction

  // idle percentage for the current traffic mix
  function automatic int idle_pct(input bit receiver_side);
    case ((accepted_reqs / 29) % 4)
      1:       return receiver_side ? 0 : 46;
      2:       return receiver_side ? 46 : 0;
      3:       return 19;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatches < 40)
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    mismatches++;
  endtask

  // request driver
  always @(posedge clk_i) begin : feed
    request_t nxt;
    if (rst_ni && (!req_valid || in_ready_o)) begin
      if (nonce_requests.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
        nxt = nonce_requests.pop_front();
        req_valid <= 1'b1;
        req_cmd   <= nxt.cmd;
        req_nonce <= nxt.nonce;
        req_count <= nxt.count;
        req_now   <= nxt.now;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result receiver
  always @(posedge clk_i) begin
    resp_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
  end

  // model update on every transfer, result checking
  always @(posedge clk_i) begin : scoreboard
    outcome_t want;
    request_t seen;
    if (rst_ni) begin
      if (cfg_valid && cfg_ready_o) limit_model = cfg_data;
      if (out_valid_o && resp_ready) begin
        if (expected_answers.size() == 0) begin
          report_mismatch("result with nothing expected", {62'd0, status_o}, '0);
        end else begin
          want = expected_answers.pop_front();
          if (status_o !== want.status)
            report_mismatch("status", {62'd0, status_o}, {62'd0, want.status});
          if (slot_index_o !== want.slot)
            report_mismatch("slot_index", {54'd0, slot_index_o}, {54'd0, want.slot});
          if (evicted_o !== want.evicted)
            report_mismatch("evicted", {63'd0, evicted_o}, {63'd0, want.evicted});
          if (accepted_nonce_o !== want.echo)
            report_mismatch("accepted_nonce", accepted_nonce_o, want.echo);
        end
      end
      if (req_valid && in_ready_o) begin
        seen.cmd   = req_cmd;
        seen.nonce = req_nonce;
        seen.count = req_count;
        seen.now   = req_now;
        expected_answers.push_back(table_answer(seen));
        accepted_reqs <= accepted_reqs + 1;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin : watchdog
    int quiet;
    if ((req_valid && in_ready_o) || (out_valid_o && resp_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet == STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic queue_request(input logic [1:0] c, input logic [63:0] n,
                               input logic [31:0] u, input logic [31:0] t);
    request_t r;
    r.cmd   = c;
    r.nonce = n;
    r.count = u;
    r.now   = t;
    nonce_requests.push_back(r);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    while (nonce_requests.size() != 0 || req_valid || expected_answers.size() != 0)
      @(negedge clk_i);
  endtask

  // limit register write once the block has gone idle
  task automatic set_limit(input logic [10:0] v);
    wait_drained();
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  function automatic logic [31:0] pick_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return $urandom;
    if (r < 65) return 32'($urandom_range(0, 3));
    if (r < 75) return '1;
    clock_secs = clock_secs + 32'($urandom_range(0, 50));
    return clock_secs;
  endfunction

  function automatic logic [31:0] pick_count(input int idx);
    logic [31:0] base;
    base = (idx >= 0) ? known_counts[idx] : '0;
    case ($urandom_range(0, 5))
      0:       return base;
      1:       return base + 32'd1;
      2:       return base - 32'd1;
      3:       return $urandom;
      4:       return '0;
      default: return '1;
    endcase
  endfunction

  // random traffic, mostly against nonces that were created before
  task automatic queue_random(input int items);
    int k, pick, idx;
    logic [63:0] key;
    logic [31:0] cnt;
    logic [1:0]  cmd;
    for (k = 0; k < items; k++) begin
      pick = $urandom_range(0, 99);
      idx  = -1;
      if (known_nonces.size() != 0 && (pick >= 30 || $urandom_range(0, 99) < 30))
        idx = $urandom_range(0, known_nonces.size() - 1);
      // occasional probe for a nonce nobody created
      if (pick >= 30 && $urandom_range(0, 9) == 0) idx = -1;
      key = (idx >= 0) ? known_nonces[idx] : {$urandom, $urandom};
      if (pick < 30) begin
        if (idx < 0) begin
          if (known_nonces.size() < POOL_MAX) begin
            known_nonces.push_back(key);
            known_counts.push_back('0);
          end else begin
            idx = $urandom_range(0, POOL_MAX - 1);
            known_nonces[idx] = key;
            known_counts[idx] = '0;
          end
        end
        queue_request(CMD_CREATE, key, $urandom, pick_time());
      end else if (pick < 95) begin
        cnt = pick_count(idx);
        cmd = (pick < 60) ? CMD_UPDATE : CMD_VALIDATE;
        if (cmd == CMD_UPDATE && idx >= 0 && cnt > known_counts[idx])
          known_counts[idx] = cnt;
        queue_request(cmd, key, cnt, $urandom);
      end else begin
        queue_request(CMD_UNUSED, key, $urandom, $urandom);
      end
    end
  endtask

  // stimulus
  initial begin : stimulus
    int p;
    int unsigned phase_limit [10];
    int phase_items [10];
    phase_limit = '{1, 6, 0, 12, 2047, 20, 1024, 40, 48, 3};
    phase_items = '{40, 60, 40, 70, 50, 60, 50, 70, 70, 70};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // limit of zero behaves as one
    set_limit(11'd0);
    queue_request(CMD_VALIDATE, 64'h0, 32'd0, 32'd0);
    queue_request(CMD_CREATE,   64'h0, 32'd0, 32'd5);
    queue_request(CMD_CREATE,   64'h0, 32'd0, 32'd9);
    queue_request(CMD_VALIDATE, 64'h0, 32'd0, 32'd0);
    queue_request(CMD_VALIDATE, 64'h0, 32'd1, 32'd0);
    queue_request(CMD_UPDATE,   64'h0, 32'd1, 32'd0);
    queue_request(CMD_UPDATE,   64'h0, 32'd1, 32'd0);
    queue_request(CMD_UPDATE,   64'h0, '1, 32'd0);
    queue_request(CMD_VALIDATE, 64'h0, '1, 32'd0);
    queue_request(CMD_UNUSED,   64'h0, '1, '1);
    queue_request(CMD_CREATE,   '1, '1, '1);

    // ties on the maximum creation time evict the lowest slot
    set_limit(11'd4);
    queue_request(CMD_CREATE,   64'hAAAA_AAAA_AAAA_AAAA, 32'd0, '1);
    queue_request(CMD_CREATE,   64'h5555_5555_5555_5555, 32'd0, '1);
    queue_request(CMD_CREATE,   64'h0123_4567_89AB_CDEF, 32'd0, '1);
    queue_request(CMD_CREATE,   64'hFEDC_BA98_7654_3210, 32'd0, 32'd0);
    queue_request(CMD_CREATE,   64'h8000_0000_0000_0001, 32'd0, 32'd7);
    queue_request(CMD_VALIDATE, '1, 32'd1, 32'd0);
    queue_request(CMD_UPDATE,   64'h5555_5555_5555_5555, 32'd9, 32'd0);

    // limit lowered below the records in use
    set_limit(11'd2);
    queue_request(CMD_CREATE,   64'h7FFF_FFFF_FFFF_FFFE, 32'd0, 32'd3);
    queue_request(CMD_VALIDATE, 64'h5555_5555_5555_5555, 32'd9, 32'd0);
    queue_request(CMD_CREATE,   64'h5555_5555_5555_5555, 32'd0, 32'd3);

    // random phases, limits ordered so the table stays small
    for (p = 0; p < 10; p++) begin
      set_limit(11'(phase_limit[p]));
      queue_random(phase_items[p]);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && expected_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/nrt_pkg.sv
design/nrt_store.sv
design/nonce_replay_table.sv
tb/tb_nonce_replay_table.sv
